// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ntw_pkg.sv =====
// ----------------------------------------------------------------------------
// ntw_pkg
// shared types and word codes for the number to word token block
// ----------------------------------------------------------------------------
package ntw_pkg;

  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned NUM_DIG  = 10;
  localparam int unsigned BCD_W    = 4 * NUM_DIG;
  localparam int unsigned WORD_W   = 5;
  localparam int unsigned NUM_GRP  = 4;
  localparam int unsigned NUM_PH   = 5;
  localparam int unsigned SLOT_W   = NUM_GRP * NUM_PH;

  // word codes
  localparam logic [WORD_W-1:0] CODE_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] CODE_TEN       = 5'd10;
  localparam logic [WORD_W-1:0] CODE_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] CODE_HUNDRED   = 5'd28;
  localparam logic [WORD_W-1:0] CODE_THOUSAND  = 5'd29;
  localparam logic [WORD_W-1:0] CODE_MILLION   = 5'd30;
  localparam logic [WORD_W-1:0] CODE_BILLION   = 5'd31;

  // token slots inside one digit group
  localparam int unsigned PH_HUND_DIGIT = 0;
  localparam int unsigned PH_HUNDRED    = 1;
  localparam int unsigned PH_TENS       = 2;
  localparam int unsigned PH_ONES       = 3;
  localparam int unsigned PH_SCALE      = 4;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef struct packed {
    logic valid;
    bcd_t digits;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== hw/rtl/number_to_word_tokens.sv =====
// ----------------------------------------------------------------------------
// number_to_word_tokens
// spells a 31-bit unsigned value as a stream of english word codes
// ----------------------------------------------------------------------------
// channel  dir  tdata                       tlast
// s_axis   in   [30:0] value, [31] pad      -
// m_axis   out  [4:0] word_code, [7:5] zero  last_word
//
// the front converts one value to decimal two bits per cycle (through the
// shift-and-add-three unit), after a step to take the value and before a step
// that hands it to the queue, and takes no new value until that hand-off; the
// back sends one token per cycle while m_axis is not stalled, 1 to 16 per value
// a value waits in the queue while the back is busy, and the back sends no
// token while it loads a new digit set
// reset is asynchronous and active low; it empties the queue and drops tvalid
// a stall on m_axis only backs up the queue; s_axis stalls once it is full
// ----------------------------------------------------------------------------
module number_to_word_tokens #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [30:0] value, [31] pad
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] word_code, [7:5] pad
  output logic       m_axis_tlast    // last_word
);
  import ntw_pkg::*;

  push_t             push;
  fifo_status_t      fifo_status;
  bcd_t              head;
  logic              pop;
  logic [WORD_W-1:0] word_code;

  // front: transfer in and binary to decimal conversion
  ntw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_value_i    (s_axis_tdata[VALUE_W-1:0]),
    .fifo_status_i (fifo_status),
    .push_o        (push)
  );

  // digit sets waiting for the token sequencer
  ntw_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (fifo_status)
  );

  // back: token sequencer with output register
  ntw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_code_o    (word_code),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, word_code};

endmodule

// ===== hw/rtl/ntw_front.sv =====
// ----------------------------------------------------------------------------
// ntw_front
// accepts a value and converts it to ten decimal digits, two bits per cycle
// ----------------------------------------------------------------------------
module ntw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ntw_pkg::VALUE_W-1:0]   in_value_i,
  input  ntw_pkg::fifo_status_t         fifo_status_i,
  output ntw_pkg::push_t                push_o
);
  import ntw_pkg::*;

  localparam int unsigned SH_W  = 32;
  localparam int unsigned CNT_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_e;

  state_e            state_q;
  logic [SH_W-1:0]   sh_q;
  bcd_t              bcd_q;
  logic [CNT_W-1:0]  cnt_q;
  bcd_t              bcd_mid;
  bcd_t              bcd_d;
  logic [SH_W-1:0]   sh_d;

  // add three to every digit of five or more, then shift in one bit
  function automatic bcd_t dabble_step(bcd_t b, logic bit_in);
    bcd_t adj;
    adj = b;
    for (int k = 0; k < NUM_DIG; k++) begin
      if (b[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = b[4*k +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  always_comb begin
    bcd_mid = dabble_step(bcd_q, sh_q[SH_W-1]);
    bcd_d   = dabble_step(bcd_mid, sh_q[SH_W-2]);
    sh_d    = {sh_q[SH_W-3:0], 2'b00};
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign push_o.valid  = (state_q == ST_PUSH) && !fifo_status_i.full;
  assign push_o.digits = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sh_q    <= {1'b0, in_value_i};
            bcd_q   <= '0;
            cnt_q   <= '1;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          sh_q  <= sh_d;
          bcd_q <= bcd_d;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!fifo_status_i.full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ntw_fifo.sv =====
// ----------------------------------------------------------------------------
// ntw_fifo
// short queue of converted digit sets between front and back
// ----------------------------------------------------------------------------
module ntw_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ntw_pkg::push_t        push_i,
  input  logic                  pop_i,
  output ntw_pkg::bcd_t         head_o,
  output ntw_pkg::fifo_status_t status_o
);
  import ntw_pkg::*;

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  bcd_t             mem_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (count_q == CNT_W'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i.valid && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.digits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ntw_back.sv =====
// ----------------------------------------------------------------------------
// ntw_back
// walks the digit groups and sends one word token per cycle unless the output stalls
// ----------------------------------------------------------------------------
module ntw_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ntw_pkg::bcd_t                 head_i,
  input  ntw_pkg::fifo_status_t         fifo_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ntw_pkg::WORD_W-1:0]    out_code_o,
  output logic                          out_last_o
);
  import ntw_pkg::*;

  logic                busy_q;
  bcd_t                digits_q;
  logic [SLOT_W-1:0]   mask_q;
  logic                out_valid_q;
  logic [WORD_W-1:0]   out_code_q;
  logic                out_last_q;

  logic [SLOT_W-1:0]   mask_rest;
  logic                sel_last;
  logic [1:0]          sel_grp;
  logic [2:0]          sel_ph;
  logic [3:0]          g_h;
  logic [3:0]          g_t;
  logic [3:0]          g_o;
  logic [WORD_W-1:0]   sel_code;
  logic                out_free;
  logic                emit;

  // hundreds, tens and ones digit of group g (billions group first)
  function automatic logic [11:0] group_digits(bcd_t b, logic [1:0] g);
    logic [11:0] r;
    case (g)
      2'd0:    r = {8'h00, b[39:36]};
      2'd1:    r = b[35:24];
      2'd2:    r = b[23:12];
      default: r = b[11:0];
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] build_mask(bcd_t b);
    logic [SLOT_W-1:0] m;
    logic [11:0]       d;
    m = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      d = group_digits(b, 2'(g));
      m[g*NUM_PH + PH_HUND_DIGIT] = (d[11:8] != 4'd0);
      m[g*NUM_PH + PH_HUNDRED]    = (d[11:8] != 4'd0);
      m[g*NUM_PH + PH_TENS]       = (d[7:4] != 4'd0);
      m[g*NUM_PH + PH_ONES]       = (d[7:4] != 4'd1) && (d[3:0] != 4'd0);
      m[g*NUM_PH + PH_SCALE]      = (g != NUM_GRP - 1) && (d != 12'h000);
    end
    return m;
  endfunction

  // lowest pending slot
  always_comb begin
    sel_grp = '0;
    sel_ph  = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      for (int p = NUM_PH - 1; p >= 0; p--) begin
        if (mask_q[g*NUM_PH + p]) begin
          sel_grp = 2'(g);
          sel_ph  = 3'(p);
        end
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - 1'b1);
  assign sel_last  = (mask_rest == '0);
  assign {g_h, g_t, g_o} = group_digits(digits_q, sel_grp);

  always_comb begin
    sel_code = CODE_ZERO;
    if (mask_q != '0) begin
      case (sel_ph)
        3'(PH_HUND_DIGIT): sel_code = {1'b0, g_h};
        3'(PH_HUNDRED):    sel_code = CODE_HUNDRED;
        3'(PH_TENS): begin
          if (g_t == 4'd1) begin
            sel_code = CODE_TEN + {1'b0, g_o};
          end else begin
            sel_code = CODE_TENS_BASE + {1'b0, g_t};
          end
        end
        3'(PH_ONES):       sel_code = {1'b0, g_o};
        default: begin
          case (sel_grp)
            2'd0:    sel_code = CODE_BILLION;
            2'd1:    sel_code = CODE_MILLION;
            default: sel_code = CODE_THOUSAND;
          endcase
        end
      endcase
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = busy_q && out_free;
  assign pop_o       = !busy_q && !fifo_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digits_q <= head_i;
    end
    if (emit) begin
      out_code_q <= sel_code;
      out_last_q <= sel_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        mask_q <= build_mask(head_i);
      end else if (emit) begin
        mask_q <= mask_rest;
        if (sel_last) begin
          busy_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/ntw_checker.sv =====
// ----------------------------------------------------------------------------
// ntw_checker
// port level checks on the token stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import ntw_pkg::*;

  logic out_stall;
  logic out_xfer;
  logic in_xfer;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign in_xfer   = s_axis_tvalid && s_axis_tready && (s_axis_tdata[31] == 1'b0);

  // a stalled token holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // the zero word is always flagged as the last word
  `ASSERT_SAME(a_zero_last, clk_i, rst_ni,
               m_axis_tvalid && (m_axis_tdata[4:0] == CODE_ZERO), m_axis_tlast)
  // hundred is never followed by hundred within one number
  `ASSERT_NEXT(a_hundred_pair, clk_i, rst_ni,
               out_xfer && (m_axis_tdata[4:0] == CODE_HUNDRED) && !m_axis_tlast,
               !(m_axis_tvalid && (m_axis_tdata[4:0] == CODE_HUNDRED)))
  // the front takes at most one value per conversion
  `ASSERT_NEXT(a_in_spacing, clk_i, rst_ni, in_xfer, !s_axis_tready)

endmodule

bind number_to_word_tokens ntw_checker u_ntw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== test/number_to_word_tokens_tb.sv =====
// ----------------------------------------------------------------------------
// number_to_word_tokens_tb
// drives 31-bit values into the word token block and checks every token on
// the output stream against typed tokens or the local speller; a directed table
// comes first, then random values under several sender/receiver idling patterns
// ----------------------------------------------------------------------------
module number_to_word_tokens_tb;
  import ntw_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RAND_PER_PH  = 31;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_DIRECTED = 26;
  localparam int unsigned NUM_PHASES   = 4;

  // one token as seen on m_axis
  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic              last;
  } word_tok_t;

  // directed row: raw tdata and how many typed-in tokens it owns (0: use speller)
  typedef struct packed {
    logic [31:0] tdata;
    logic [4:0]  n_typed;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{32'd0,          5'd1},   // zero right after reset
    '{32'h7fff_ffff,  5'd16},  // largest value, longest token run
    '{32'h8000_0000,  5'd1},   // pad bit set, value zero
    '{32'd1000000000, 5'd2},
    '{32'd19,         5'd1},
    '{32'd20,         5'd1},
    '{32'd1,          5'd0},
    '{32'd9,          5'd0},
    '{32'd10,         5'd0},
    '{32'd11,         5'd0},
    '{32'd15,         5'd0},
    '{32'd21,         5'd0},
    '{32'd99,         5'd0},
    '{32'd100,        5'd0},
    '{32'd101,        5'd0},
    '{32'd110,        5'd0},
    '{32'd115,        5'd0},
    '{32'd999,        5'd0},
    '{32'd1000,       5'd0},
    '{32'd1001,       5'd0},
    '{32'd1000000,    5'd0},
    '{32'd1010010,    5'd0},
    '{32'd12345,      5'd0},
    '{32'd2000000000, 5'd0},
    '{32'h8000_000c,  5'd0},   // pad bit set over a small value
    '{32'd700000007,  5'd0}
  };

  // typed-in tokens of the rows above, in row order
  localparam logic [WORD_W-1:0] TYPED_WORDS [22] = '{
    CODE_ZERO,
    // two billion one hundred forty seven million four hundred eighty three
    // thousand six hundred forty seven
    5'd2, CODE_BILLION, 5'd1, CODE_HUNDRED, CODE_TENS_BASE + 5'd4, 5'd7, CODE_MILLION,
    5'd4, CODE_HUNDRED, CODE_TENS_BASE + 5'd8, 5'd3, CODE_THOUSAND,
    5'd6, CODE_HUNDRED, CODE_TENS_BASE + 5'd4, 5'd7,
    CODE_ZERO,
    5'd1, CODE_BILLION,
    CODE_TEN + 5'd9,
    CODE_TENS_BASE + 5'd2
  };

  // sender idle and receiver stall percentages per phase
  localparam int PHASE_SEND_IDLE  [NUM_PHASES] = '{0, 87, 0, 21};
  localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 87, 21};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [30:0] value, [31] pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [4:0] word_code, [7:5] pad
  logic        m_axis_tlast;        // last_word

  word_tok_t   pending_words [$];
  int unsigned cycles         = 0;
  int unsigned mismatches     = 0;
  int unsigned numbers_sent   = 0;
  int unsigned words_checked  = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  number_to_word_tokens DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // spells one value and queues its tokens, the last one flagged
  task automatic push_spelled_words(input logic [31:0] data);
    logic [VALUE_W-1:0] v;
    logic [WORD_W-1:0]  words [16];
    logic [WORD_W-1:0]  scales [NUM_GRP];
    int unsigned        divs [NUM_GRP];
    int                 n, grp, hund, tens, ones;
    word_tok_t          tok;
    v      = data[VALUE_W-1:0];  // pad bit is ignored
    divs   = '{32'd1000000000, 32'd1000000, 32'd1000, 32'd1};
    scales = '{CODE_BILLION, CODE_MILLION, CODE_THOUSAND, CODE_ZERO};
    n      = 0;
    if (v == '0) begin
      words[0] = CODE_ZERO;
      n = 1;
    end else begin
      for (int i = 0; i < NUM_GRP; i++) begin
        grp = (v / divs[i]) % 1000;
        if (grp != 0) begin
          hund = grp / 100;
          tens = (grp % 100) / 10;
          ones = grp % 10;
          if (hund != 0) begin
            words[n]   = hund[WORD_W-1:0];
            words[n+1] = CODE_HUNDRED;
            n += 2;
          end
          if (tens == 1) begin
            // ten..nineteen is one word
            words[n] = CODE_TEN + ones[WORD_W-1:0];
            n++;
          end else begin
            if (tens != 0) begin
              words[n] = CODE_TENS_BASE + tens[WORD_W-1:0];
              n++;
            end
            if (ones != 0) begin
              words[n] = ones[WORD_W-1:0];
              n++;
            end
          end
          // units group carries no scale word
          if (i < NUM_GRP - 1) begin
            words[n] = scales[i];
            n++;
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      tok.code = words[k];
      tok.last = (k == n - 1);
      pending_words.push_back(tok);
    end
  endtask

  // random value: full range, one small group, groups with zeros, near the top
  function automatic logic [31:0] random_tdata();
    longint unsigned acc;
    logic [VALUE_W-1:0] v;
    acc = 0;
    case ($urandom_range(3))
      0: v = VALUE_W'($urandom());
      1: v = VALUE_W'($urandom_range(999));
      2: begin
        acc = $urandom_range(2);
        for (int i = 0; i < NUM_GRP - 1; i++) begin
          acc = acc * 1000 + (($urandom_range(2) == 0) ? 0 : $urandom_range(999));
        end
        if (acc > 64'd2147483647) begin
          acc -= 64'd1000000000;
        end
        v = acc[VALUE_W-1:0];
      end
      default: v = 31'h7fff_ffff - VALUE_W'($urandom_range(2000));
    endcase
    return {1'($urandom_range(1)), v};
  endfunction

  // offers one value, after a random idle gap, until the block takes it;
  // returns at the edge of the transfer
  task automatic send_value(input logic [31:0] data);
    int   gap;
    logic seen;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    seen = 1'b0;
    while (!seen) begin
      @(negedge clk_i);
      seen = s_axis_tready;
      @(posedge clk_i);
    end
    numbers_sent++;
  endtask

  // sender holds off until every queued token has come back
  task automatic wait_all_words();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // receiver stalls at the phase's rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // outputs are sampled mid-cycle, so the transfer at the next edge is settled
  always @(negedge clk_i) begin
    word_tok_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected token: code %0d last %0b",
                   m_axis_tdata[WORD_W-1:0], m_axis_tlast);
        end
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[WORD_W-1:0] !== want.code || m_axis_tlast !== want.last) begin
          if (mismatches < MAX_REPORTS) begin
            $display("token %0d mismatch: expected code %0d last %0b, got code %0d last %0b",
                     words_checked, want.code, want.last,
                     m_axis_tdata[WORD_W-1:0], m_axis_tlast);
          end
          mismatches++;
        end
      end
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens pending", cycles, pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    word_tok_t tok;
    int        typed_pos;
    logic [31:0] data;
    typed_pos = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, no idling on either side
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_value(DIRECTED[r].tdata);
      if (DIRECTED[r].n_typed != 0) begin
        for (int k = 0; k < DIRECTED[r].n_typed; k++) begin
          tok.code = TYPED_WORDS[typed_pos + k];
          tok.last = (k == DIRECTED[r].n_typed - 1);
          pending_words.push_back(tok);
        end
        typed_pos += DIRECTED[r].n_typed;
      end else begin
        push_spelled_words(DIRECTED[r].tdata);
      end
    end

    // random values, one batch per idling pattern, drained in between
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_all_words();
      send_idle_pct  = PHASE_SEND_IDLE[ph];
      recv_stall_pct = PHASE_RECV_STALL[ph];
      for (int i = 0; i < RAND_PER_PH; i++) begin
        data = random_tdata();
        send_value(data);
        push_spelled_words(data);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $display("%0d tokens never arrived", pending_words.size());
      mismatches++;
    end

    $display("spelled %0d values into %0d word tokens over %0d idling patterns",
             numbers_sent, words_checked, NUM_PHASES);
    $display("%0d token errors in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== number_to_word_tokens.f =====
+incdir+hw/rtl
hw/rtl/ntw_pkg.sv
hw/rtl/ntw_front.sv
hw/rtl/ntw_fifo.sv
hw/rtl/ntw_back.sv
hw/rtl/number_to_word_tokens.sv
hw/rtl/ntw_checker.sv
test/number_to_word_tokens_tb.sv
